// ----- design/hbp_pkg.sv -----
package hbp_pkg;

  localparam int SYMBOL_COUNT     = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYM_W            = 9;
  localparam int CODE_LEN_W       = 6;
  localparam int CODE_BITS_W      = 32;
  localparam int BYTE_W           = 8;
  localparam int TAB_DEPTH        = SYMBOL_COUNT + 1;
  localparam int TAB_AW           = $clog2(TAB_DEPTH);
  localparam int QUEUE_DEPTH      = 2;

  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = ((SYM_W + CODE_LEN_W + CODE_BITS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = BYTE_W;
  localparam int OUT_TUSER_W = 1;

  localparam logic [IN_TUSER_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [IN_TUSER_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [IN_TUSER_W-1:0] MODE_FINISH = 2'd2;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_ERROR,
    KIND_FINISH
  } hbp_kind_t;

  typedef struct packed {
    hbp_kind_t                kind;
    logic [CODE_LEN_W-1:0]    len;
    logic [CODE_BITS_W-1:0]   bits;
  } hbp_cmd_t;

endpackage

// ----- design/hbp_ram.sv -----
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/hbp_front.sv -----
module hbp_front #(
  parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hbp_pkg::IN_TUSER_W-1:0] in_mode,
  input  logic [hbp_pkg::SYM_W-1:0]      in_symbol,
  input  logic [hbp_pkg::CODE_LEN_W-1:0] in_len,
  input  logic [hbp_pkg::CODE_BITS_W-1:0] in_bits,
  input  logic                           q_full,
  output logic                           q_push,
  output hbp_pkg::hbp_cmd_t              q_cmd
);
  import hbp_pkg::*;

  localparam int EFF_MAX = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
  localparam int LEN_W   = $clog2(EFF_MAX + 1);
  localparam int RAM_W   = LEN_W + CODE_BITS_W;

  logic                   acc;
  logic                   is_load;
  logic                   is_enc;
  logic                   is_fin;
  logic                   enc_oor;
  logic                   wr_en;
  logic [TAB_AW-1:0]      wr_addr;
  logic [LEN_W-1:0]       wr_len;
  logic                   rd_en;
  logic [TAB_AW-1:0]      rd_addr;
  logic [RAM_W-1:0]       rd_data;
  logic [CODE_LEN_W-1:0]  hit_len;

  logic [TAB_DEPTH-1:0]   valid_r;
  logic                   s1_v_r;
  logic                   s1_v_nxt;
  logic                   s1_fin_r;
  logic                   s1_oor_r;
  logic                   s1_hit_r;

  always_comb begin
    is_load   = (in_mode == MODE_LOAD);
    is_enc    = (in_mode == MODE_ENCODE);
    is_fin    = (in_mode == MODE_FINISH);
    q_push    = s1_v_r && !q_full;
    in_tready = !s1_v_r || q_push;
    acc       = in_tvalid && in_tready;
    enc_oor   = (in_symbol >= SYM_W'(SYMBOL_COUNT));
    wr_en     = acc && is_load && (in_symbol <= SYM_W'(SYMBOL_COUNT));
    wr_addr   = in_symbol[TAB_AW-1:0];
    wr_len    = (in_len <= CODE_LEN_W'(EFF_MAX)) ? in_len[LEN_W-1:0] : '0;
    rd_en     = acc && (is_enc || is_fin);
    rd_addr   = (is_fin || enc_oor) ? TAB_AW'(SYMBOL_COUNT) : in_symbol[TAB_AW-1:0];
    s1_v_nxt  = rd_en ? 1'b1 : (q_push ? 1'b0 : s1_v_r);
  end

  hbp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TAB_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({wr_len, in_bits}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_fin_r <= is_fin;
      s1_oor_r <= is_enc && enc_oor;
      s1_hit_r <= valid_r[rd_addr];
    end
  end

  always_comb begin
    hit_len    = s1_hit_r ? CODE_LEN_W'(rd_data[RAM_W-1 -: LEN_W]) : '0;
    q_cmd.len  = hit_len;
    q_cmd.bits = rd_data[CODE_BITS_W-1:0];
    if (s1_fin_r) begin
      q_cmd.kind = KIND_FINISH;
    end else if (s1_oor_r || (hit_len == '0)) begin
      q_cmd.kind = KIND_ERROR;
    end else begin
      q_cmd.kind = KIND_CODE;
    end
  end

`ifndef SYNTHESIS
  a_lookup_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !q_push) |=> $stable(rd_data))
    else $error("table read data changed while a lookup waited for the queue");
`endif

endmodule

// ----- design/hbp_queue.sv -----
module hbp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hbp_pkg::hbp_cmd_t cmd_in,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output hbp_pkg::hbp_cmd_t head
);
  import hbp_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  hbp_cmd_t         ent_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wp_r;
  logic [QPW-1:0]   wp_nxt;
  logic [QPW-1:0]   rp_r;
  logic [QPW-1:0]   rp_nxt;
  logic [QCW-1:0]   cnt_r;
  logic [QCW-1:0]   cnt_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full    = (cnt_r == QCW'(QUEUE_DEPTH));
    empty   = (cnt_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = ent_r[rp_r];
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("word pushed into a full command queue");
`endif

endmodule

// ----- design/hbp_back.sv -----
module hbp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  hbp_pkg::hbp_cmd_t               q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic [hbp_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import hbp_pkg::*;

  localparam int CNT_W = $clog2(BYTE_W + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [BYTE_W-1:0]        buf_r, buf_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CODE_LEN_W-1:0]    rem_r, rem_nxt;
  logic [CODE_BITS_W-1:0]   sh_r, sh_nxt;
  logic                     fin_r, fin_nxt;
  logic                     out_v_r, out_v_nxt;
  logic [BYTE_W-1:0]        out_byte_r;
  logic                     out_last_r;
  logic                     out_err_r;

  logic                     out_free;
  logic [CNT_W-1:0]         space;
  logic [CNT_W-1:0]         take;
  logic [CNT_W-1:0]         cnt_sum;
  logic                     byte_full;
  logic [CODE_LEN_W-1:0]    rem_left;
  logic [2*BYTE_W-1:0]      win;
  logic [2*BYTE_W-1:0]      fill;
  logic                     emit;
  logic [BYTE_W-1:0]        emit_byte;
  logic                     emit_last;
  logic                     emit_err;

  always_comb begin
    out_free  = !out_v_r || out_tready;
    q_pop     = (state_r == ST_IDLE) && !q_empty;
    space     = CNT_W'(BYTE_W) - cnt_r;
    take      = (rem_r >= CODE_LEN_W'(space)) ? space : CNT_W'(rem_r);
    cnt_sum   = cnt_r + take;
    byte_full = (cnt_sum == CNT_W'(BYTE_W));
    rem_left  = rem_r - CODE_LEN_W'(take);
    win       = {buf_r, sh_r[CODE_BITS_W-1 -: BYTE_W]};
    fill      = win >> (CNT_W'(BYTE_W) - take);

    state_nxt = state_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_err  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          fin_nxt = (q_head.kind == KIND_FINISH);
          rem_nxt = q_head.len;
          sh_nxt  = q_head.bits << (CODE_LEN_W'(CODE_BITS_W) - q_head.len);
          unique case (q_head.kind)
            KIND_CODE:   state_nxt = ST_SHIFT;
            KIND_ERROR:  state_nxt = ST_ERR;
            KIND_FINISH: state_nxt = (q_head.len == '0) ? ST_FIN : ST_SHIFT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT: begin
        if (!byte_full || out_free) begin
          sh_nxt  = sh_r << take;
          rem_nxt = rem_left;
          if (byte_full) begin
            emit      = 1'b1;
            emit_byte = fill[BYTE_W-1:0];
            emit_last = fin_r && (rem_left == '0);
            buf_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            buf_nxt = fill[BYTE_W-1:0];
            cnt_nxt = cnt_sum;
          end
          if (rem_left == '0) begin
            state_nxt = (fin_r && !byte_full) ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = buf_r << (CNT_W'(BYTE_W) - cnt_r);
          emit_last = 1'b1;
          buf_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_err  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase

    out_v_nxt = emit || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      buf_r   <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      fin_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      fin_r   <= fin_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

`ifndef SYNTHESIS
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_err_r) |-> ((out_byte_r == '0) && !out_last_r))
    else $error("error word carries data or a last mark");
  a_shift_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (rem_r != '0))
    else $error("packer shifting with no code bits left");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < CNT_W'(BYTE_W)))
    else $error("packer holds a full byte that was not sent");
`endif

endmodule

// ----- design/huffman_bit_packer.sv -----
// An encode or finish word is looked up in the table, queued as a command and packed into
// a registered output word; a load word gives no output.
// Throughput: the front takes one word per cycle while its two-entry command queue has room.
// The packer takes one command at a time from the queue, shifts its code out in chunks up to
// each byte boundary and sends the padded byte of a finish; it pops no command until idle.
// Reset (synchronous, active low) clears all table valid bits, the packer and the queue.
module huffman_bit_packer #(
  parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: symbol, code_length, code_bits, one zero pad bit.
  input  logic [hbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: mode.
  input  logic [hbp_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: out_byte.
  output logic [hbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // Fields from bit 0: error.
  output logic [hbp_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import hbp_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  hbp_cmd_t q_in_cmd;
  hbp_cmd_t q_head;

  hbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_symbol (in_tdata[SYM_W-1:0]),
    .in_len    (in_tdata[SYM_W +: CODE_LEN_W]),
    .in_bits   (in_tdata[SYM_W+CODE_LEN_W +: CODE_BITS_W]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  hbp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .cmd_in (q_in_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  hbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/huffman_bit_packer_test.sv -----
`timescale 1ns / 100ps

module huffman_bit_packer_test;
  import hbp_pkg::*;

  localparam int MAX_LEN = MAX_CODE_LEN_DEF;
  localparam int RAND_ITEMS = 245;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [IN_TUSER_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } packed_word_t;

  class packer_scoreboard;
    logic [CODE_LEN_W-1:0]  len_tab[TAB_DEPTH];
    logic [CODE_BITS_W-1:0] bits_tab[TAB_DEPTH];
    logic [7:0]             pend_bits;
    int                     pend_cnt;
    packed_word_t           exp_words[$];
    int                     errors;

    function new();
      foreach (len_tab[i]) begin
        len_tab[i] = '0;
        bits_tab[i] = '0;
      end
      pend_bits = '0;
      pend_cnt = 0;
      errors = 0;
    endfunction

    function void push_word(logic [7:0] data, logic last, logic err);
      packed_word_t w;
      w.data = data;
      w.last = last;
      w.err = err;
      exp_words.push_back(w);
    endfunction

    function void append_code(int idx);
      for (int i = int'(len_tab[idx]); i > 0; i--) begin
        pend_bits = {pend_bits[6:0], (i <= 32) ? bits_tab[idx][i-1] : 1'b0};
        pend_cnt++;
        if (pend_cnt == BYTE_W) begin
          push_word(pend_bits, 1'b0, 1'b0);
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
    endfunction

    function void note_input(logic [1:0] mode, logic [SYM_W-1:0] sym,
                             logic [CODE_LEN_W-1:0] len, logic [CODE_BITS_W-1:0] bits);
      int first;
      packed_word_t w;
      case (mode)
        MODE_LOAD: begin
          if (sym <= SYMBOL_COUNT) begin
            len_tab[sym] = (len > MAX_LEN || len > 32) ? '0 : len;
            bits_tab[sym] = bits;
          end
        end
        MODE_ENCODE: begin
          if (sym >= SYMBOL_COUNT || len_tab[sym] == 0) begin
            push_word(8'h00, 1'b0, 1'b1);
          end else begin
            append_code(sym);
          end
        end
        MODE_FINISH: begin
          first = exp_words.size();
          append_code(SYMBOL_COUNT);
          if (pend_cnt > 0) begin
            push_word(pend_bits << (BYTE_W - pend_cnt), 1'b0, 1'b0);
          end
          if (exp_words.size() == first) begin
            push_word(8'h00, 1'b0, 1'b0);
          end
          w = exp_words.pop_back();
          w.last = 1'b1;
          exp_words.push_back(w);
          pend_bits = '0;
          pend_cnt = 0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [7:0] data, logic last, logic err);
      packed_word_t w;
      if (exp_words.size() == 0) begin
        $error("unexpected output word: out_byte %0h, last %0b, error %0b", data, last, err);
        errors++;
      end else begin
        w = exp_words.pop_front();
        if (data !== w.data) begin
          $error("out_byte mismatch: expected %0h, actual %0h", w.data, data);
          errors++;
        end
        if (last !== w.last) begin
          $error("last mismatch: expected %0b, actual %0b", w.last, last);
          errors++;
        end
        if (err !== w.err) begin
          $error("error mismatch: expected %0b, actual %0b", w.err, err);
          errors++;
        end
      end
    endfunction

    function int pending();
      return exp_words.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  logic calm;
  logic hold_req;
  packer_scoreboard sb;

  huffman_bit_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_word(input logic [1:0] mode, input logic [SYM_W-1:0] sym,
                           input logic [CODE_LEN_W-1:0] len,
                           input logic [CODE_BITS_W-1:0] bits);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {1'b0, bits, len, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(mode, sym, len, bits);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser[0]);
    end
  end

  initial begin
    int hold_cnt;
    bit hold_done;
    hold_cnt = 0;
    hold_done = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) hold_done = 1;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int pick;
    int sym;
    int len;
    logic [31:0] bits;
    bit has_code[SYMBOL_COUNT];
    int coded_q[$];
    sb = new();
    foreach (has_code[i]) has_code[i] = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_LOAD;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: missing code, then a finish that emits nothing but the last word.
    send_word(MODE_ENCODE, 9'd5, 6'd0, 32'h0);
    send_word(MODE_FINISH, 9'd0, 6'd0, 32'h0);
    send_word(MODE_LOAD, 9'd511, 6'd5, 32'h1F);
    send_word(MODE_LOAD, 9'd0, 6'd32, 32'hFFFF_FFFF);
    send_word(MODE_LOAD, 9'd255, 6'd1, 32'hFFFF_FFFE);
    send_word(MODE_LOAD, 9'd1, 6'd33, 32'h1234_5678);
    send_word(MODE_LOAD, 9'd2, 6'd63, 32'h0);
    send_word(MODE_LOAD, 9'd3, 6'd8, 32'hFFFF_FFA5);
    send_word(MODE_LOAD, 9'd256, 6'd3, 32'h5);
    send_word(MODE_ENCODE, 9'd0, 6'd63, 32'hFFFF_FFFF);
    send_word(MODE_ENCODE, 9'd255, 6'd0, 32'h0);
    send_word(MODE_ENCODE, 9'd1, 6'd0, 32'h0);
    send_word(MODE_ENCODE, 9'd2, 6'd0, 32'h0);
    send_word(MODE_ENCODE, 9'd256, 6'd0, 32'h0);
    send_word(MODE_ENCODE, 9'd511, 6'd0, 32'h0);
    send_word(MODE_ENCODE, 9'd3, 6'd0, 32'h0);
    send_word(MODE_FINISH, 9'd0, 6'd0, 32'h0);
    send_word(MODE_UNUSED, 9'd511, 6'd63, 32'hFFFF_FFFF);
    send_word(MODE_LOAD, 9'd4, 6'd7, 32'h0000_005A);
    send_word(MODE_ENCODE, 9'd4, 6'd0, 32'h0);
    send_word(MODE_LOAD, 9'd256, 6'd0, 32'hFFFF_FFFF);
    send_word(MODE_FINISH, 9'd511, 6'd63, 32'hFFFF_FFFF);
    send_word(MODE_LOAD, 9'd256, 6'd8, 32'h0000_00C3);
    send_word(MODE_ENCODE, 9'd3, 6'd0, 32'h0);
    send_word(MODE_FINISH, 9'd0, 6'd0, 32'h0);
    has_code[0] = 1;
    has_code[255] = 1;
    has_code[3] = 1;
    has_code[4] = 1;
    coded_q = '{0, 255, 3, 4};

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm <= (n >= 150 && n < 220);
      if (n == 60) hold_req <= 1'b1;
      pick = $urandom_range(99);
      bits = $urandom;
      if (pick < 60) begin
        sym = coded_q[$urandom_range(coded_q.size() - 1)];
        send_word(MODE_ENCODE, sym[8:0], 6'($urandom_range(63)), bits);
      end else if (pick < 76) begin
        sym = $urandom_range(SYMBOL_COUNT);
        len = ($urandom_range(3) == 0) ? $urandom_range(32, 1) : $urandom_range(8, 1);
        case ($urandom_range(9))
          0: len = $urandom_range(63, 33);
          1: sym = $urandom_range(511, SYMBOL_COUNT + 1);
          2: len = 0;
          default: begin
          end
        endcase
        if (sym < SYMBOL_COUNT) begin
          has_code[sym] = (len >= 1 && len <= MAX_LEN);
          if (has_code[sym]) coded_q.push_back(sym);
        end
        send_word(MODE_LOAD, sym[8:0], len[5:0], bits);
      end else if (pick < 86) begin
        send_word(MODE_FINISH, 9'($urandom_range(511)), 6'($urandom_range(63)), bits);
      end else if (pick < 96) begin
        send_word(MODE_ENCODE, 9'($urandom_range(511)), 6'($urandom_range(63)), bits);
      end else begin
        send_word(MODE_UNUSED, 9'($urandom_range(511)), 6'($urandom_range(63)), bits);
      end
    end
    send_word(MODE_FINISH, 9'd0, 6'd0, 32'h0);
    in_tvalid <= 1'b0;
    calm <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
